// File: rtl/cdwo_pkg.sv
// ----------------------------------------------------------------------------
// cdwo_pkg
// shared constants, transaction types and the quarter-wave sine generator
// ----------------------------------------------------------------------------
package cdwo_pkg;

    // oscillator dimensions
    localparam int PHASE_BITS         = 32;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SAMPLE_RATE_HZ     = 44100;

    // field widths
    localparam int DIST_W      = 13;
    localparam int TONE_W      = 11;
    localparam int VOL_W       = 7;
    localparam int AUDIO_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;

    // sine table geometry
    localparam int SINE_IDX_W  = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_ADDR_W = SINE_IDX_W + 1;
    localparam int SINE_W      = 16;
    localparam int SINE_DEPTH  = SINE_TABLE_ENTRIES + 1;

    // sample scaling: magnitude = (volume * gain * operand) >> shift
    localparam int MAG_W       = 15;
    localparam int COEF_W      = 15;
    localparam int OPERAND_W   = PHASE_BITS + 1;
    localparam int PROD_W      = COEF_W + OPERAND_W;
    localparam int SINE_GAIN   = 75;    // 30000 / (100 * 32768) = 75 / 8192
    localparam int SINE_SHIFT  = 13;
    localparam int SQUARE_GAIN = 45;    // 30000 * 0.15 / 100
    localparam int TRI_GAIN    = 210;   // 30000 * 0.7 / 100
    localparam int VOL_MAX     = 100;
    localparam int VOL_RESET   = 50;

    // distance to frequency mapping
    localparam int DIST_MIN_MM     = 50;
    localparam int DIST_MAX_MM     = 400;
    localparam int FREQ_MIN_HZ     = 100;
    localparam int FREQ_MAX_HZ     = 2000;
    localparam int FREQ_DEFAULT_HZ = 440;
    localparam int OFFSET_W        = $clog2(DIST_MAX_MM - DIST_MIN_MM + 1);
    // (x * 1900 / 350) == (x * 38 * ceil(2^17 / 7)) >> 17 over the whole span
    localparam int FREQ_SHIFT      = 17;
    localparam int FREQ_MUL        = 38 * (((1 << FREQ_SHIFT) + 6) / 7);
    localparam int FREQ_MUL_W      = $clog2(FREQ_MUL + 1);
    localparam int FREQ_PROD_W     = OFFSET_W + FREQ_MUL_W;

    // phase step = floor(f * 2^PHASE_BITS / rate) by reciprocal multiply
    localparam int STEP_SHIFT  = TONE_W + $clog2(SAMPLE_RATE_HZ);
    localparam int STEP_MUL_W  = PHASE_BITS + STEP_SHIFT;
    localparam logic [STEP_MUL_W:0] STEP_NUM = (STEP_MUL_W + 1)'(1) << STEP_MUL_W;
    localparam logic [STEP_MUL_W-1:0] STEP_MUL =
        STEP_MUL_W'((STEP_NUM + (STEP_MUL_W + 1)'(SAMPLE_RATE_HZ - 1)) / SAMPLE_RATE_HZ);
    localparam int STEP_PROD_W = TONE_W + STEP_MUL_W;
    localparam logic [PHASE_BITS-1:0] STEP_RESET =
        PHASE_BITS'(((PHASE_BITS + TONE_W)'(FREQ_DEFAULT_HZ) << PHASE_BITS)
                    / SAMPLE_RATE_HZ);

    // sine series
    localparam logic [63:0] HALF_PI_Q30  = 64'd1686629713;
    localparam int          Q30_FRAC     = 30;
    localparam int          TAYLOR_TERMS = 6;
    localparam int          SINE_FULL    = 32768;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2
    } wave_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVE_SHAPE = 2'd0,
        CFG_VOLUME     = 2'd1,
        CFG_PLAYING    = 2'd2
    } cfg_reg_t;

    localparam logic REQ_DISTANCE = 1'b0;
    localparam logic REQ_TICK     = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [DIST_W-1:0] distance_mm;
        logic              range_ok;
    } in_item_t;

    typedef struct packed {
        logic                      sample_valid;
        logic signed [AUDIO_W-1:0] audio_sample;
        logic [TONE_W-1:0]         pitch_hz;
    } out_item_t;

    // tone unit status seen by the sample path
    typedef struct packed {
        logic                  busy;
        logic [TONE_W-1:0]     tone;
        logic [TONE_W-1:0]     tone_new;
        logic [PHASE_BITS-1:0] step;
    } pitch_state_t;

    // one quarter-wave entry, Q30 series up to x^13, rounded to Q15
    function automatic logic [SINE_W-1:0] sine_entry(input int unsigned idx);
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] mag;
        logic [63:0] e;
        longint      sum;
        int unsigned k;
        x   = (HALF_PI_Q30 * 64'(idx)) / SINE_TABLE_ENTRIES;
        t   = x;
        sum = longint'(x);
        for (k = 1; k <= TAYLOR_TERMS; k++) begin
            t = (t * x) >> Q30_FRAC;
            t = (t * x) >> Q30_FRAC;
            t = t / 64'((2 * k) * (2 * k + 1));
            if (k[0])
                sum = sum - longint'(t);
            else
                sum = sum + longint'(t);
        end
        if (sum < 0)
            sum = 0;
        mag = 64'(sum);
        e   = (mag * 64'(SINE_FULL) + (64'd1 << (Q30_FRAC - 1))) >> Q30_FRAC;
        if (e > 64'(SINE_FULL))
            e = 64'(SINE_FULL);
        return SINE_W'(e);
    endfunction

endpackage

// File: rtl/distance_controlled_waveform_oscillator.sv
// ----------------------------------------------------------------------------
// distance_controlled_waveform_oscillator
// a result passes the stage 1, stage 2 and output registers after its transaction is accepted
// throughput: one sample tick per cycle while the result channel does not stall; a distance
//   transaction holds ready low for the following cycle while the phase step multiply completes
// reset: registers to defaults (sine, volume 50, silent), tone 440 Hz, phase 0;
//   the sine table is constant, so no clearing pass is needed
// ----------------------------------------------------------------------------
module distance_controlled_waveform_oscillator (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             item_valid,
    output logic                             item_ready,
    input  cdwo_pkg::in_item_t               item,
    // result channel
    output logic                             result_valid,
    input  logic                             result_ready,
    output cdwo_pkg::out_item_t              result,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [cdwo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [cdwo_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    cdwo_pkg::wave_t                  wave_shape_reg;
    logic [cdwo_pkg::VOL_W-1:0]       volume_reg;      // held already saturated
    logic                             playing_reg;

    // phase accumulator
    logic [cdwo_pkg::PHASE_BITS-1:0]  phase_accum_reg;
    logic [cdwo_pkg::PHASE_BITS-1:0]  phase_accum_next;

    // handshake and stage flow
    logic                             accept;
    logic                             is_tick;
    logic                             tick_fire;
    logic                             enter_s1;
    logic                             out_free;
    logic                             s1_free;
    logic                             s2_free;
    logic                             s1_move;
    logic                             s2_move;

    cdwo_pkg::pitch_state_t           pitch;

    // stage 1: phase snapshot
    logic                             s1_valid_reg;
    logic                             s1_tick_reg;
    logic [cdwo_pkg::PHASE_BITS-1:0]  s1_phase_reg;
    logic [cdwo_pkg::TONE_W-1:0]      s1_pitch_reg;

    // stage 1 decode
    logic [cdwo_pkg::SINE_IDX_W+1:0]  sine_idx;
    logic [cdwo_pkg::SINE_IDX_W-1:0]  sine_k;
    logic [cdwo_pkg::SINE_ADDR_W-1:0] sine_addr;
    logic [cdwo_pkg::PHASE_BITS+1:0]  tri_full;
    logic [cdwo_pkg::PHASE_BITS+1:0]  tri_twop;
    logic [cdwo_pkg::PHASE_BITS+1:0]  tri_a;
    logic [cdwo_pkg::PHASE_BITS+1:0]  tri_twoa;
    logic [cdwo_pkg::PHASE_BITS+1:0]  tri_num;
    logic                             tri_neg;
    logic                             s1_neg;
    logic [cdwo_pkg::OPERAND_W-1:0]   s1_num;
    logic [cdwo_pkg::COEF_W-1:0]      s1_coef;

    // stage 2: scale operands, table data arrives from the rom
    logic                             s2_valid_reg;
    logic                             s2_tick_reg;
    logic [cdwo_pkg::TONE_W-1:0]      s2_pitch_reg;
    logic                             s2_neg_reg;
    logic [cdwo_pkg::OPERAND_W-1:0]   s2_num_reg;
    logic [cdwo_pkg::COEF_W-1:0]      s2_coef_reg;
    logic [cdwo_pkg::SINE_W-1:0]      sine_q;

    // stage 2 scaling
    logic [cdwo_pkg::OPERAND_W-1:0]   operand;
    logic [cdwo_pkg::PROD_W-1:0]      prod;
    logic [cdwo_pkg::MAG_W-1:0]       mag;
    logic signed [cdwo_pkg::AUDIO_W-1:0] mag_s;
    logic signed [cdwo_pkg::AUDIO_W-1:0] sample_next;

    // output register
    logic                             result_valid_reg;
    cdwo_pkg::out_item_t              result_reg;

    // ------------------------------------------------------------------
    // configuration: volume saturates at 100 as it is written
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_shape_reg <= cdwo_pkg::WAVE_SINE;
            volume_reg     <= cdwo_pkg::VOL_W'(cdwo_pkg::VOL_RESET);
            playing_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cdwo_pkg::cfg_reg_t'(cfg_index))
                cdwo_pkg::CFG_WAVE_SHAPE:
                    wave_shape_reg <= cdwo_pkg::wave_t'(cfg_data[1:0]);
                cdwo_pkg::CFG_VOLUME:
                    volume_reg <= (cfg_data > cdwo_pkg::CFG_DATA_W'(cdwo_pkg::VOL_MAX))
                                  ? cdwo_pkg::VOL_W'(cdwo_pkg::VOL_MAX)
                                  : cdwo_pkg::VOL_W'(cfg_data);
                cdwo_pkg::CFG_PLAYING:
                    playing_reg <= cfg_data[0];
                default:
                    ;   // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // flow control: each stage refills as soon as its content moves on
    // ------------------------------------------------------------------
    assign out_free   = !result_valid_reg || result_ready;
    assign s2_free    = !s2_valid_reg || out_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign s2_move    = s2_valid_reg && out_free;
    assign s1_move    = s1_valid_reg && s2_free;

    // hold off in the cycle after a distance transaction so the next tick
    // sees the new phase step
    assign item_ready = s1_free && !pitch.busy;
    assign accept     = item_valid && item_ready;
    assign is_tick    = (item.req_type == cdwo_pkg::REQ_TICK);
    assign tick_fire  = accept && is_tick && playing_reg;
    // a tick while silent produces nothing and is simply consumed
    assign enter_s1   = accept && (!is_tick || playing_reg);

    cdwo_pitch u_pitch (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept && !is_tick),
        .item  (item),
        .state (pitch)
    );

    // ------------------------------------------------------------------
    // phase accumulator: the sample uses the phase before the add
    // ------------------------------------------------------------------
    assign phase_accum_next = tick_fire ? (phase_accum_reg + pitch.step) : phase_accum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_accum_reg <= '0;
        end
        else
        begin
            phase_accum_reg <= phase_accum_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_free)
        begin
            s1_valid_reg <= enter_s1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter_s1)
        begin
            s1_tick_reg  <= is_tick;
            s1_phase_reg <= phase_accum_reg;
            s1_pitch_reg <= is_tick ? pitch.tone : pitch.tone_new;
        end
    end

    always_comb
    begin
        // quadrant from the top two index bits, mirrored read on odd quadrants
        sine_idx  = s1_phase_reg[cdwo_pkg::PHASE_BITS-1 -: cdwo_pkg::SINE_IDX_W + 2];
        sine_k    = sine_idx[cdwo_pkg::SINE_IDX_W-1:0];
        sine_addr = sine_idx[cdwo_pkg::SINE_IDX_W]
                    ? cdwo_pkg::SINE_ADDR_W'(cdwo_pkg::SINE_TABLE_ENTRIES)
                      - cdwo_pkg::SINE_ADDR_W'(sine_k)
                    : cdwo_pkg::SINE_ADDR_W'(sine_k);

        // triangle: num = |2 * |2p - 2^B| - 2^B|, negative below the midline
        tri_full  = (cdwo_pkg::PHASE_BITS + 2)'(1) << cdwo_pkg::PHASE_BITS;
        tri_twop  = {1'b0, s1_phase_reg, 1'b0};
        tri_a     = (tri_twop >= tri_full) ? (tri_twop - tri_full) : (tri_full - tri_twop);
        tri_twoa  = tri_a << 1;
        tri_neg   = (tri_twoa < tri_full);
        tri_num   = tri_neg ? (tri_full - tri_twoa) : (tri_twoa - tri_full);

        case (wave_shape_reg)
            cdwo_pkg::WAVE_SINE:
            begin
                s1_neg  = sine_idx[cdwo_pkg::SINE_IDX_W+1];
                s1_num  = '0;
                s1_coef = cdwo_pkg::COEF_W'(volume_reg)
                          * cdwo_pkg::COEF_W'(cdwo_pkg::SINE_GAIN);
            end
            cdwo_pkg::WAVE_SQUARE:
            begin
                s1_neg  = s1_phase_reg[cdwo_pkg::PHASE_BITS-1];
                s1_num  = cdwo_pkg::OPERAND_W'(1);
                s1_coef = cdwo_pkg::COEF_W'(volume_reg)
                          * cdwo_pkg::COEF_W'(cdwo_pkg::SQUARE_GAIN);
            end
            cdwo_pkg::WAVE_TRIANGLE:
            begin
                s1_neg  = tri_neg;
                s1_num  = cdwo_pkg::OPERAND_W'(tri_num);
                s1_coef = cdwo_pkg::COEF_W'(volume_reg)
                          * cdwo_pkg::COEF_W'(cdwo_pkg::TRI_GAIN);
            end
            default:
            begin
                // unused shape code gives a silent but valid sample
                s1_neg  = 1'b0;
                s1_num  = '0;
                s1_coef = '0;
            end
        endcase
    end

    cdwo_sine_rom u_sine_rom (
        .clk   (clk),
        .rd_en (s1_move),
        .addr  (sine_addr),
        .data  (sine_q)
    );

    // ------------------------------------------------------------------
    // stage 2
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_tick_reg  <= s1_tick_reg;
            s2_pitch_reg <= s1_pitch_reg;
            s2_neg_reg   <= s1_neg;
            s2_num_reg   <= s1_num;
            s2_coef_reg  <= s1_coef;
        end
    end

    // one shared multiplier; the shape picks operand and binary point
    always_comb
    begin
        operand = (wave_shape_reg == cdwo_pkg::WAVE_SINE)
                  ? cdwo_pkg::OPERAND_W'(sine_q) : s2_num_reg;
        prod    = cdwo_pkg::PROD_W'(s2_coef_reg) * cdwo_pkg::PROD_W'(operand);
        case (wave_shape_reg)
            cdwo_pkg::WAVE_SINE:
                mag = prod[cdwo_pkg::SINE_SHIFT +: cdwo_pkg::MAG_W];
            cdwo_pkg::WAVE_SQUARE:
                mag = prod[cdwo_pkg::MAG_W-1:0];
            cdwo_pkg::WAVE_TRIANGLE:
                mag = prod[cdwo_pkg::PHASE_BITS +: cdwo_pkg::MAG_W];
            default:
                mag = '0;
        endcase
        mag_s = $signed({1'b0, mag});
        if (!s2_tick_reg)
            sample_next = '0;
        else if (s2_neg_reg)
            sample_next = -mag_s;
        else
            sample_next = mag_s;
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            result_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            result_reg.sample_valid <= s2_tick_reg;
            result_reg.audio_sample <= sample_next;
            result_reg.pitch_hz     <= s2_pitch_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !tick_fire |=> $stable(phase_accum_reg))
        else $error("phase moved without a playing tick");

    a_silent_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.sample_valid) |-> (result_reg.audio_sample == '0))
        else $error("distance result carries a nonzero sample");

    a_sample_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.audio_sample <= 16'sd30000
                              && result_reg.audio_sample >= -16'sd30000))
        else $error("audio sample beyond full scale");

    a_pitch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (result_reg.pitch_hz >= cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_MIN_HZ)
                              && result_reg.pitch_hz <= cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_MAX_HZ)))
        else $error("reported pitch out of range");

endmodule

// File: rtl/cdwo_sine_rom.sv
// ----------------------------------------------------------------------------
// cdwo_sine_rom
// quarter-wave sine table with registered read data
// ----------------------------------------------------------------------------
module cdwo_sine_rom (
    input  logic                             clk,
    input  logic                             rd_en,
    input  logic [cdwo_pkg::SINE_ADDR_W-1:0] addr,
    output logic [cdwo_pkg::SINE_W-1:0]      data
);

    logic [cdwo_pkg::SINE_W-1:0] rom [0:cdwo_pkg::SINE_DEPTH-1];
    logic [cdwo_pkg::SINE_W-1:0] data_reg;

    for (genvar g = 0; g < cdwo_pkg::SINE_DEPTH; g++) begin : g_entry
        localparam logic [cdwo_pkg::SINE_W-1:0] ENTRY = cdwo_pkg::sine_entry(g);
        assign rom[g] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

// File: rtl/cdwo_pitch.sv
// ----------------------------------------------------------------------------
// cdwo_pitch
// distance to tone frequency mapping and phase step recalculation
// ----------------------------------------------------------------------------
module cdwo_pitch (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  cdwo_pkg::in_item_t     item,
    output cdwo_pkg::pitch_state_t state
);

    logic [cdwo_pkg::TONE_W-1:0]      tone_freq_reg;
    logic [cdwo_pkg::TONE_W-1:0]      tone_freq_next;
    logic [cdwo_pkg::PHASE_BITS-1:0]  phase_step_reg;
    logic [cdwo_pkg::PHASE_BITS-1:0]  phase_step_next;
    logic                             busy_reg;
    logic [cdwo_pkg::OFFSET_W-1:0]    offset;
    logic [cdwo_pkg::FREQ_PROD_W-1:0] freq_prod;
    logic [cdwo_pkg::STEP_PROD_W-1:0] step_prod;

    // linear map with truncation, clamped at both ends
    always_comb
    begin
        offset    = cdwo_pkg::OFFSET_W'(item.distance_mm
                                        - cdwo_pkg::DIST_W'(cdwo_pkg::DIST_MIN_MM));
        freq_prod = cdwo_pkg::FREQ_PROD_W'(offset)
                    * cdwo_pkg::FREQ_PROD_W'(cdwo_pkg::FREQ_MUL);
        if (!item.range_ok)
            tone_freq_next = cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_DEFAULT_HZ);
        else if (item.distance_mm < cdwo_pkg::DIST_W'(cdwo_pkg::DIST_MIN_MM))
            tone_freq_next = cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_MIN_HZ);
        else if (item.distance_mm > cdwo_pkg::DIST_W'(cdwo_pkg::DIST_MAX_MM))
            tone_freq_next = cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_MAX_HZ);
        else
            tone_freq_next = freq_prod[cdwo_pkg::FREQ_SHIFT +: cdwo_pkg::TONE_W]
                             + cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_MIN_HZ);
    end

    // step from the registered tone, taken in the cycle after the load
    always_comb
    begin
        step_prod       = cdwo_pkg::STEP_PROD_W'(tone_freq_reg)
                          * cdwo_pkg::STEP_PROD_W'(cdwo_pkg::STEP_MUL);
        phase_step_next = step_prod[cdwo_pkg::STEP_SHIFT +: cdwo_pkg::PHASE_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tone_freq_reg  <= cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_DEFAULT_HZ);
            phase_step_reg <= cdwo_pkg::STEP_RESET;
            busy_reg       <= 1'b0;
        end
        else
        begin
            busy_reg <= load;
            if (load)
            begin
                tone_freq_reg <= tone_freq_next;
            end
            if (busy_reg)
            begin
                phase_step_reg <= phase_step_next;
            end
        end
    end

    assign state.busy     = busy_reg;
    assign state.tone     = tone_freq_reg;
    assign state.tone_new = tone_freq_next;
    assign state.step     = phase_step_reg;

    // step update never overlaps a second load
    a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg)
        else $error("phase step update lasted more than one cycle");

    a_tone_range: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (tone_freq_reg >= cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_MIN_HZ)
                  && tone_freq_reg <= cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_MAX_HZ)))
        else $error("tone frequency left its range");

endmodule

// File: dv/distance_controlled_waveform_oscillator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_controlled_waveform_oscillator_test
// self-checking bench: directed and random distance and tick transactions,
// each result checked field by field against an in-bench oscillator predictor
// ----------------------------------------------------------------------------
module distance_controlled_waveform_oscillator_test;

    // bench timing
    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 6;
    localparam int CYCLE_LIMIT    = 200000;

    // oscillator arithmetic, worked out independently of the design
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int          SERIES_ORDERS    = 6;
    localparam int          FULL_SCALE       = 30000;
    localparam int          SQUARE_STEP      = 45;     // 30000 * 0.15 / 100
    localparam int          RAMP_STEP        = 210;    // 30000 * 0.7 / 100
    localparam int          VOL_CEILING      = (1 << cdwo_pkg::VOL_W) - 1;

    // codes the package has no name for
    localparam logic [1:0]                       WAVE_UNUSED  = 2'd3;
    localparam logic [cdwo_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;

    // dut connections, all inputs known from time zero
    logic                             clk          = 1'b0;
    logic                             rst_n        = 1'b0;
    logic                             item_valid   = 1'b0;
    logic                             item_ready;
    cdwo_pkg::in_item_t               item         = '0;
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    cdwo_pkg::out_item_t              result;
    logic                             cfg_we       = 1'b0;
    logic [cdwo_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [cdwo_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

    // predictor state: a private copy of the oscillator and its registers
    int                               quarter_wave [0:cdwo_pkg::SINE_TABLE_ENTRIES];
    logic [cdwo_pkg::PHASE_BITS-1:0]  phase_accum;
    logic [cdwo_pkg::PHASE_BITS-1:0]  phase_step;
    logic [cdwo_pkg::TONE_W-1:0]      tone_hz;
    logic [1:0]                       wave_sel;
    logic [cdwo_pkg::VOL_W-1:0]       volume_pct;
    logic                             playing_on;

    // outputs still owed by the dut, oldest first
    cdwo_pkg::out_item_t              awaited_outputs [$];

    // idling knobs, in percent of cycles
    int                     send_idle_pct = 34;
    int                     recv_idle_pct = 81;

    // bookkeeping
    int                     fault_count     = 0;
    int                     items_sent      = 0;
    int                     silent_ticks    = 0;
    int                     samples_checked = 0;
    int                     pitches_checked = 0;
    int unsigned            cycle_count     = 0;

    distance_controlled_waveform_oscillator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge clk)
    begin
        result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("cycle limit reached with %0d outputs outstanding",
                   awaited_outputs.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // predictor: applies one accepted transaction to the private oscillator,
    // returns 1 with the expected output when the transaction produces one
    function automatic bit predict_oscillator(input cdwo_pkg::in_item_t req,
                                              output cdwo_pkg::out_item_t res);
        int                  freq;
        longint unsigned     vol;
        longint unsigned     mag;
        longint unsigned     idx;
        longint unsigned     ent;
        longint unsigned     full;
        longint unsigned     twop;
        longint unsigned     fold;
        longint unsigned     twoa;
        longint unsigned     num;
        int unsigned         quad;
        int unsigned         k;
        bit                  neg;
        res  = '0;
        mag  = 0;
        neg  = 1'b0;
        full = 64'd1 << cdwo_pkg::PHASE_BITS;
        if (req.req_type == cdwo_pkg::REQ_DISTANCE)
        begin
            // linear map with truncation toward zero, then clamp;
            // an invalid reading falls back to concert pitch
            freq = cdwo_pkg::FREQ_DEFAULT_HZ;
            if (req.range_ok)
            begin
                freq = (int'(req.distance_mm) - cdwo_pkg::DIST_MIN_MM)
                       * (cdwo_pkg::FREQ_MAX_HZ - cdwo_pkg::FREQ_MIN_HZ)
                       / (cdwo_pkg::DIST_MAX_MM - cdwo_pkg::DIST_MIN_MM)
                       + cdwo_pkg::FREQ_MIN_HZ;
                if (freq < cdwo_pkg::FREQ_MIN_HZ)
                    freq = cdwo_pkg::FREQ_MIN_HZ;
                if (freq > cdwo_pkg::FREQ_MAX_HZ)
                    freq = cdwo_pkg::FREQ_MAX_HZ;
            end
            tone_hz      = cdwo_pkg::TONE_W'(freq);
            phase_step   = cdwo_pkg::PHASE_BITS'((64'(tone_hz) << cdwo_pkg::PHASE_BITS)
                                                 / cdwo_pkg::SAMPLE_RATE_HZ);
            res.pitch_hz = tone_hz;
            return 1'b1;
        end
        // silent ticks leave the phase alone
        if (!playing_on)
            return 1'b0;
        vol = (volume_pct > cdwo_pkg::VOL_MAX) ? cdwo_pkg::VOL_MAX : volume_pct;
        case (wave_sel)
            cdwo_pkg::WAVE_SINE:
            begin
                // quarter-wave lookup, mirrored and negated per quadrant
                idx  = (64'(phase_accum) * (4 * cdwo_pkg::SINE_TABLE_ENTRIES))
                       >> cdwo_pkg::PHASE_BITS;
                quad = int'((idx / cdwo_pkg::SINE_TABLE_ENTRIES) % 4);
                k    = int'(idx % cdwo_pkg::SINE_TABLE_ENTRIES);
                ent  = (quad % 2)
                       ? 64'(quarter_wave[cdwo_pkg::SINE_TABLE_ENTRIES - k])
                       : 64'(quarter_wave[k]);
                neg  = (quad >= 2);
                mag  = (FULL_SCALE * vol * ent) / (100 * cdwo_pkg::SINE_FULL);
            end
            cdwo_pkg::WAVE_SQUARE:
            begin
                neg = phase_accum[cdwo_pkg::PHASE_BITS-1];
                mag = SQUARE_STEP * vol;
            end
            cdwo_pkg::WAVE_TRIANGLE:
            begin
                twop = 2 * 64'(phase_accum);
                fold = (twop >= full) ? (twop - full) : (full - twop);
                twoa = 2 * fold;
                neg  = (twoa < full);
                num  = neg ? (full - twoa) : (twoa - full);
                mag  = (RAMP_STEP * vol * num) >> cdwo_pkg::PHASE_BITS;
            end
            default:
            begin
                mag = 0;
            end
        endcase
        res.sample_valid = 1'b1;
        res.audio_sample = cdwo_pkg::AUDIO_W'(neg ? -longint'(mag) : longint'(mag));
        res.pitch_hz     = tone_hz;
        phase_accum      = phase_accum + phase_step;
        return 1'b1;
    endfunction

    // result checker: every accepted output against the oldest prediction
    always @(posedge clk)
    begin
        cdwo_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_outputs.size() == 0)
            begin
                $error("result transaction with nothing outstanding: %p", result);
                fault_count++;
            end
            else
            begin
                want = awaited_outputs.pop_front();
                if (result.sample_valid !== want.sample_valid)
                begin
                    $error("sample_valid mismatch: expected %0d, actual %0d",
                           want.sample_valid, result.sample_valid);
                    fault_count++;
                end
                if (result.audio_sample !== want.audio_sample)
                begin
                    $error("audio_sample mismatch: expected %0d, actual %0d",
                           want.audio_sample, result.audio_sample);
                    fault_count++;
                end
                if (result.pitch_hz !== want.pitch_hz)
                begin
                    $error("pitch_hz mismatch: expected %0d, actual %0d",
                           want.pitch_hz, result.pitch_hz);
                    fault_count++;
                end
                if (want.sample_valid)
                    samples_checked++;
                else
                    pitches_checked++;
            end
        end
    end

    // one request transaction; valid is only dropped when a gap is drawn,
    // so back-to-back transactions keep it high across the handover edge
    task automatic send_item(input cdwo_pkg::in_item_t req);
        cdwo_pkg::out_item_t res;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= req;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        items_sent++;
        if (predict_oscillator(req, res))
            awaited_outputs.push_back(res);
        else
            silent_ticks++;
    endtask

    // let every owed output arrive, then give the pipeline time to empty
    // (silent ticks may still be in flight with nothing to wait on)
    task automatic drain_results();
        item_valid <= 1'b0;
        while (awaited_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // register write, only ever issued with the block idle
    task automatic write_register(input logic [cdwo_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [cdwo_pkg::CFG_DATA_W-1:0]  data);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (index)
            cdwo_pkg::CFG_WAVE_SHAPE: wave_sel   = data[1:0];
            cdwo_pkg::CFG_VOLUME:     volume_pct = data;
            cdwo_pkg::CFG_PLAYING:    playing_on = data[0];
            default:                  ;
        endcase
        @(posedge clk);
    endtask

    // defaults after reset: silent, concert pitch, sine at half volume, phase zero
    task automatic test_reset_state();
        cdwo_pkg::in_item_t req;
        // tick while silent: no output and the phase must not move
        req.req_type    = cdwo_pkg::REQ_TICK;
        req.distance_mm = '1;
        req.range_ok    = 1'b1;
        send_item(req);
        // start playing: first sample is taken at phase zero, second one step on
        write_register(cdwo_pkg::CFG_PLAYING, cdwo_pkg::CFG_DATA_W'(1));
        send_item(req);
        send_item(req);
        // out-of-range reading selects 440 Hz
        req.req_type    = cdwo_pkg::REQ_DISTANCE;
        req.range_ok    = 1'b0;
        send_item(req);
    endtask

    // distance to pitch, including both clamps and both alternating-bit readings
    task automatic test_pitch_mapping();
        cdwo_pkg::in_item_t req;
        int                 readings [9];
        int                 n;
        readings = '{0, 49, 50, 51, 225, 400, 401, 5461, 2730};
        for (n = 0; n < 9; n++)
        begin
            req.req_type    = cdwo_pkg::REQ_DISTANCE;
            req.distance_mm = cdwo_pkg::DIST_W'(readings[n]);
            req.range_ok    = 1'b1;
            send_item(req);
        end
    endtask

    // every wave shape, the unused code too, at full, zero and saturated volume;
    // a write to the unmapped register index must change nothing
    task automatic test_wave_shapes();
        cdwo_pkg::in_item_t req;
        int                 levels [3];
        int                 shape;
        int                 lvl;
        levels          = '{cdwo_pkg::VOL_MAX, 0, VOL_CEILING};
        req.req_type    = cdwo_pkg::REQ_TICK;
        req.distance_mm = '0;
        req.range_ok    = 1'b0;
        for (shape = cdwo_pkg::WAVE_SINE; shape <= WAVE_UNUSED; shape++)
        begin
            write_register(cdwo_pkg::CFG_WAVE_SHAPE, cdwo_pkg::CFG_DATA_W'(shape));
            for (lvl = 0; lvl < 3; lvl++)
            begin
                write_register(cdwo_pkg::CFG_VOLUME, cdwo_pkg::CFG_DATA_W'(levels[lvl]));
                if (shape == WAVE_UNUSED && lvl == 2)
                    write_register(CFG_UNMAPPED, '1);
                send_item(req);
            end
        end
    endtask

    // random stretches of traffic, each under a fresh register setting;
    // only transactions that produce an output count toward the target
    task automatic test_random_traffic(input int target);
        cdwo_pkg::in_item_t              req;
        logic [cdwo_pkg::CFG_DATA_W-1:0] data;
        int                              produced;
        int                              burst;
        int                              roll;
        produced = 0;
        while (produced < target)
        begin
            // shape code rides in the low bits, upper bits are don't-care noise
            write_register(cdwo_pkg::CFG_WAVE_SHAPE,
                           cdwo_pkg::CFG_DATA_W'($urandom_range(0, VOL_CEILING)));
            roll = $urandom_range(0, 9);
            case (roll)
                0:       data = '0;
                1:       data = cdwo_pkg::CFG_DATA_W'(cdwo_pkg::VOL_MAX);
                2:       data = '1;
                3:       data = cdwo_pkg::CFG_DATA_W'($urandom_range(cdwo_pkg::VOL_MAX + 1,
                                                                     VOL_CEILING));
                default: data = cdwo_pkg::CFG_DATA_W'($urandom_range(1,
                                                                     cdwo_pkg::VOL_MAX - 1));
            endcase
            write_register(cdwo_pkg::CFG_VOLUME, data);
            // mostly playing, now and then a silent stretch
            data    = cdwo_pkg::CFG_DATA_W'($urandom_range(0, VOL_CEILING));
            data[0] = ($urandom_range(0, 9) != 0);
            write_register(cdwo_pkg::CFG_PLAYING, data);
            burst = $urandom_range(8, 40);
            repeat (burst)
            begin
                roll            = $urandom_range(0, 99);
                req.req_type    = (roll < 85) ? cdwo_pkg::REQ_TICK : cdwo_pkg::REQ_DISTANCE;
                req.distance_mm = cdwo_pkg::DIST_W'($urandom_range(0,
                                                    (1 << cdwo_pkg::DIST_W) - 1));
                req.range_ok    = 1'($urandom_range(0, 1));
                // most retunes land in or just around the mapped span
                if (roll >= 85 && roll < 96)
                begin
                    req.distance_mm = cdwo_pkg::DIST_W'($urandom_range(
                                          cdwo_pkg::DIST_MIN_MM - 10,
                                          cdwo_pkg::DIST_MAX_MM + 10));
                    req.range_ok    = 1'b1;
                end
                if (req.req_type == cdwo_pkg::REQ_DISTANCE || playing_on)
                    produced++;
                send_item(req);
            end
        end
    endtask

    initial
    begin
        longint unsigned angle;
        longint unsigned term;
        longint unsigned rounded;
        longint          series;
        int              entry;
        int              order;

        // quarter-wave table: Q30 Taylor series to x^13, rounded to Q15, clamped
        for (entry = 0; entry <= cdwo_pkg::SINE_TABLE_ENTRIES; entry++)
        begin
            angle  = (QUARTER_TURN_Q30 * 64'(entry)) / cdwo_pkg::SINE_TABLE_ENTRIES;
            term   = angle;
            series = longint'(angle);
            for (order = 1; order <= SERIES_ORDERS; order++)
            begin
                term = (term * angle) >> 30;
                term = (term * angle) >> 30;
                term = term / 64'((2 * order) * (2 * order + 1));
                if (order % 2)
                    series -= longint'(term);
                else
                    series += longint'(term);
            end
            if (series < 0)
                series = 0;
            rounded = (64'(series) * cdwo_pkg::SINE_FULL + (64'd1 << 29)) >> 30;
            quarter_wave[entry] = (rounded > cdwo_pkg::SINE_FULL)
                                  ? cdwo_pkg::SINE_FULL : int'(rounded);
        end

        // predictor state as it stands after reset
        phase_accum = '0;
        tone_hz     = cdwo_pkg::TONE_W'(cdwo_pkg::FREQ_DEFAULT_HZ);
        phase_step  = cdwo_pkg::PHASE_BITS'((64'(tone_hz) << cdwo_pkg::PHASE_BITS)
                                            / cdwo_pkg::SAMPLE_RATE_HZ);
        wave_sel    = cdwo_pkg::WAVE_SINE;
        volume_pct  = cdwo_pkg::VOL_W'(cdwo_pkg::VOL_RESET);
        playing_on  = 1'b0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sender sparse, receiver stalling heavily
        send_idle_pct = 34;
        recv_idle_pct = 81;
        test_reset_state();
        test_pitch_mapping();
        test_wave_shapes();
        test_random_traffic(120);

        // roles swapped
        send_idle_pct = 81;
        recv_idle_pct = 34;
        test_random_traffic(120);

        // full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(120);

        drain_results();

        $display("covered %0d request transactions: %0d samples and %0d pitch updates checked,",
                 items_sent, samples_checked, pitches_checked);
        $display("%0d silent ticks, all wave codes, volume 0 to %0d, three idling mixes",
                 silent_ticks, VOL_CEILING);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
